>>> design/cprv_pkg.sv
package cprv_pkg;

	// Fixed widths of the configuration registers and the result
	localparam int LOC_W   = 32;
	localparam int SCALE_W = 31;
	localparam int VAR_W   = 32;
	localparam int CFG_W   = 32;

	localparam logic [LOC_W-1:0]   LOC_RESET   = 32'sh0000_0000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 31'h0001_0000;

	localparam logic [VAR_W-1:0] VAR_MAX = {1'b0, {(VAR_W-1){1'b1}}};
	localparam logic [VAR_W-1:0] VAR_MIN = {1'b1, {(VAR_W-1){1'b0}}};

	// Register indexes on the configuration channel
	typedef enum logic [0:0] {
		REG_LOCATION = 1'b0,
		REG_SCALE    = 1'b1
	} cprv_reg_t;

	// Control that travels alongside each item through the pipe
	typedef struct packed {
		logic valid;
		logic neg;
	} cprv_ctrl_t;

endpackage

>>> design/cauchy_polar_ratio_variate.sv
// Path: from input beat to result beat an item passes the centre, multiply and
//   radius-test registers, one divider cell per quotient bit
//   (31 + UNIFORM_BITS cells), then one output register.
// Throughput: one pair of uniforms per cycle unless the output stalls; a rejected pair yields no beat.
// Reset: arst_n clears all valid bits, location to 0 and scale to 1.0.
module cauchy_polar_ratio_variate #(
	parameter int UNIFORM_BITS = 24
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0]       s_tdata,   // first_uniform, second_uniform, zero pad
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [cprv_pkg::VAR_W-1:0]                m_tdata,   // variate
	output logic                                      m_tuser,   // saturated
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [0:0]                                cfg_index,
	input  logic [cprv_pkg::CFG_W-1:0]                cfg_data
);
	import cprv_pkg::*;

	localparam int UB  = UNIFORM_BITS;
	localparam int PW  = SCALE_W + UNIFORM_BITS;
	localparam int TDW = ((2*UNIFORM_BITS+7)/8)*8;

	logic [LOC_W-1:0]   location_q;
	logic [SCALE_W-1:0] scale_q;
	logic               en;

	cprv_ctrl_t    ctrl_c [PW+1];
	logic [UB-1:0] rem_c  [PW+1];
	logic [PW-1:0] num_c  [PW+1];
	logic [UB-1:0] div_c  [PW+1];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			location_q <= LOC_RESET;
			scale_q    <= SCALE_RESET;
		end else if (cfg_valid) begin
			case (cprv_reg_t'(cfg_index))
				REG_LOCATION: location_q <= cfg_data[LOC_W-1:0];
				REG_SCALE:    scale_q    <= cfg_data[SCALE_W-1:0];
				default:      ;
			endcase
		end
	end

	// front end: skid, centring, products, rejection
	cprv_prep #(
		.UNIFORM_BITS(UNIFORM_BITS),
		.PW          (PW),
		.TDW         (TDW)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.scale   (scale_q),
		.ctrl_out(ctrl_c[0]),
		.prod_out(num_c[0]),
		.div_out (div_c[0])
	);

	assign rem_c[0] = '0;

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < PW; i++) begin : g_cell
		cprv_div_cell #(
			.UNIFORM_BITS(UNIFORM_BITS),
			.PW          (PW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctrl_in (ctrl_c[i]),
			.rem_in  (rem_c[i]),
			.num_in  (num_c[i]),
			.div_in  (div_c[i]),
			.ctrl_out(ctrl_c[i+1]),
			.rem_out (rem_c[i+1]),
			.num_out (num_c[i+1]),
			.div_out (div_c[i+1])
		);
	end

	// location add, saturation, output register
	cprv_out #(
		.PW(PW)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_in (ctrl_c[PW]),
		.quot    (num_c[PW]),
		.location(location_q),
		.en      (en),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

>>> design/cprv_prep.sv
module cprv_prep #(
	parameter int UNIFORM_BITS = 24,
	parameter int PW           = 55,
	parameter int TDW          = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [TDW-1:0]              s_tdata,   // first_uniform, second_uniform, zero pad
	input  logic [cprv_pkg::SCALE_W-1:0] scale,
	output cprv_pkg::cprv_ctrl_t        ctrl_out,
	output logic [PW-1:0]               prod_out,
	output logic [UNIFORM_BITS-1:0]     div_out
);
	import cprv_pkg::*;

	localparam int UB = UNIFORM_BITS;
	localparam int SQ_W = 2 * UB;
	localparam logic [UB-1:0]   HALF   = UB'(1) << (UB - 1);
	localparam logic [SQ_W:0]   ONE_SQ = (SQ_W + 1)'(1) << (SQ_W - 2);

	logic [TDW-1:0] skid_q;
	logic           skid_full_q;
	logic           take;
	logic           src_valid;
	logic [TDW-1:0] src_data;
	logic [UB-1:0]  u1, u2, a1, a2;
	logic           zneg1, zneg2;

	// stage registers
	logic          v_s1, neg_s1;
	logic [UB-1:0] a1_s1, a2_s1;
	logic          v_s2, neg_s2;
	logic [PW-1:0] prod_s2;
	logic [SQ_W-1:0] sq1_s2, sq2_s2;
	logic [UB-1:0] a2_s2;
	logic          v_s3, neg_s3;
	logic [PW-1:0] prod_s3;
	logic [UB-1:0] a2_s3;
	logic [SQ_W:0] rsq;

	// skid stage: one beat is held while the pipe is stalled
	assign s_tready  = !skid_full_q;
	assign take      = s_tvalid && s_tready;
	assign src_valid = skid_full_q || s_tvalid;
	assign src_data  = skid_full_q ? skid_q : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (take) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !en) begin
			skid_q <= s_tdata;
		end
	end

	// centre each sample: magnitude and sign of u - half
	assign u1    = src_data[UB-1:0];
	assign u2    = src_data[2*UB-1:UB];
	assign zneg1 = !u1[UB-1];
	assign zneg2 = !u2[UB-1];
	assign a1    = u1[UB-1] ? (u1 - HALF) : (HALF - u1);
	assign a2    = u2[UB-1] ? (u2 - HALF) : (HALF - u2);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (a2_s2 != '0) && !(rsq > ONE_SQ);
		end
	end

	// radius squared of the point
	assign rsq = {1'b0, sq1_s2} + {1'b0, sq2_s2};

	// payload: centre, multiply, radius test
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= zneg1 ^ zneg2;
			a1_s1   <= a1;
			a2_s1   <= a2;
			neg_s2  <= neg_s1;
			prod_s2 <= PW'(scale) * PW'(a1_s1);
			sq1_s2  <= SQ_W'(a1_s1) * SQ_W'(a1_s1);
			sq2_s2  <= SQ_W'(a2_s1) * SQ_W'(a2_s1);
			a2_s2   <= a2_s1;
			neg_s3  <= neg_s2;
			prod_s3 <= prod_s2;
			a2_s3   <= a2_s2;
		end
	end

	assign ctrl_out.valid = v_s3;
	assign ctrl_out.neg   = neg_s3;
	assign prod_out       = prod_s3;
	assign div_out        = a2_s3;

endmodule

>>> design/cprv_div_cell.sv
module cprv_div_cell #(
	parameter int UNIFORM_BITS = 24,
	parameter int PW           = 55
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  cprv_pkg::cprv_ctrl_t     ctrl_in,
	input  logic [UNIFORM_BITS-1:0]  rem_in,
	input  logic [PW-1:0]            num_in,
	input  logic [UNIFORM_BITS-1:0]  div_in,
	output cprv_pkg::cprv_ctrl_t     ctrl_out,
	output logic [UNIFORM_BITS-1:0]  rem_out,
	output logic [PW-1:0]            num_out,
	output logic [UNIFORM_BITS-1:0]  div_out
);
	import cprv_pkg::*;

	localparam int UB = UNIFORM_BITS;

	logic             valid_q;
	logic             neg_q;
	logic [UB-1:0]    rem_q;
	logic [PW-1:0]    num_q;
	logic [UB-1:0]    div_q;
	logic [UB:0]      r_sh;
	logic [UB:0]      r_sub;
	logic             ge;

	// one restoring step: bring down the next dividend bit, try the subtract
	assign r_sh  = {rem_in, num_in[PW-1]};
	assign r_sub = r_sh - {1'b0, div_in};
	assign ge    = r_sh >= {1'b0, div_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctrl_in.valid;
		end
	end

	// quotient bits shift in at the bottom as the dividend leaves the top
	always_ff @(posedge clk) begin
		if (en) begin
			neg_q <= ctrl_in.neg;
			rem_q <= ge ? r_sub[UB-1:0] : r_sh[UB-1:0];
			num_q <= {num_in[PW-2:0], ge};
			div_q <= div_in;
		end
	end

	assign ctrl_out.valid = valid_q;
	assign ctrl_out.neg   = neg_q;
	assign rem_out        = rem_q;
	assign num_out        = num_q;
	assign div_out        = div_q;

endmodule

>>> design/cprv_out.sv
module cprv_out #(
	parameter int PW = 55
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cprv_pkg::cprv_ctrl_t       ctrl_in,
	input  logic [PW-1:0]              quot,
	input  logic [cprv_pkg::LOC_W-1:0] location,
	output logic                       en,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cprv_pkg::VAR_W-1:0] m_tdata,   // variate
	output logic                       m_tuser    // saturated
);
	import cprv_pkg::*;

	localparam int SW = PW + 2;

	logic             m_tvalid_q;
	logic [VAR_W-1:0] variate_q;
	logic             sat_q;
	logic [SW-1:0]    loc_ext;
	logic [SW-1:0]    q_ext;
	logic [SW-1:0]    term;
	logic [SW-1:0]    sum;
	logic [SW-VAR_W:0] hi;
	logic             in_range;

	// pipe moves whenever the output register is free or being drained
	assign en = !m_tvalid_q || m_tready;

	// add location, then clamp to 32 bits
	assign loc_ext  = {{(SW-LOC_W){location[LOC_W-1]}}, location};
	assign q_ext    = {2'b00, quot};
	assign term     = ctrl_in.neg ? (~q_ext + SW'(1)) : q_ext;
	assign sum      = loc_ext + term;
	assign hi       = sum[SW-1:VAR_W-1];
	assign in_range = (&hi) || !(|hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= ctrl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_q <= !in_range;
			if (in_range) begin
				variate_q <= sum[VAR_W-1:0];
			end else if (sum[SW-1]) begin
				variate_q <= VAR_MIN;
			end else begin
				variate_q <= VAR_MAX;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = variate_q;
	assign m_tuser  = sat_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cprv_pkg::*;

	localparam int    UB          = 24;
	localparam longint HALF       = 64'sd1 <<< (UB - 1);
	localparam longint ONE_SQ     = 64'sd1 <<< (2 * (UB - 1));
	localparam longint VAR_TOP    = 64'sd2147483647;
	localparam longint VAR_BOT    = -64'sd2147483648;
	localparam int    DRAIN_GAP   = 80;    // longer than the pipe
	localparam int    IDLE_LIMIT  = 5000;  // cycles without any beat
	localparam int    HOLD_CYCLES = 400;
	localparam int    PHASE_DRAWS = 160;

	typedef struct packed {
		logic [VAR_W-1:0] variate;
		logic             saturated;
	} draw_t;

	typedef enum logic {ROW_SETUP, ROW_PAIR} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] loc;
		logic [31:0] scl;
		logic [UB-1:0] u1;
		logic [UB-1:0] u2;
		logic        typed;
		logic        kept;
		draw_t       want;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [((2*UB+7)/8)*8-1:0] s_tdata;  // first_uniform, second_uniform
	logic m_tvalid;
	logic m_tready;
	logic [VAR_W-1:0] m_tdata;            // variate
	logic m_tuser;                        // saturated
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// predictor copy of the registers
	logic signed [LOC_W-1:0] loc_q;
	logic [SCALE_W-1:0]      scale_q;

	draw_t pending_draws[$];
	draw_t head_draw;
	row_t  plan[$];
	int    errors;
	int    n_pairs;
	int    n_kept;
	int    n_draws;
	int    n_sat;
	int    idle_cycles;
	int    hold_left;
	logic  quiet;
	logic  stall_req;
	logic  stall_taken;

	cauchy_polar_ratio_variate #(.UNIFORM_BITS(UB)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("mismatch at %0t: %s want %h got %h", $time, what, want, got);
		errors++;
	endtask

	// centre both samples, reject outside the unit circle or on a zero divisor,
	// else location + scale*z1/z2 truncated toward zero, clamped to 32 bits
	function automatic logic predict_draw(input logic [UB-1:0] u1,
			input logic [UB-1:0] u2, output draw_t d);
		longint z1, z2, a1, a2, q, sum;
		logic flip;
		d = '0;
		z1 = longint'({40'd0, u1}) - HALF;
		z2 = longint'({40'd0, u2}) - HALF;
		a1 = (z1 < 0) ? -z1 : z1;
		a2 = (z2 < 0) ? -z2 : z2;
		if (a2 == 0 || a1 * a1 + a2 * a2 > ONE_SQ) return 1'b0;
		q = (longint'({33'd0, scale_q}) * a1) / a2;
		flip = (z1 < 0) != (z2 < 0);
		sum = longint'(loc_q) + (flip ? -q : q);
		if (sum > VAR_TOP) begin
			sum = VAR_TOP;
			d.saturated = 1'b1;
		end else if (sum < VAR_BOT) begin
			sum = VAR_BOT;
			d.saturated = 1'b1;
		end
		d.variate = sum[31:0];
		return 1'b1;
	endfunction

	function automatic row_t mk_setup(input logic [31:0] loc, input logic [31:0] scl);
		row_t r;
		r = '{kind: ROW_SETUP, loc: loc, scl: scl, u1: '0, u2: '0,
			typed: 1'b0, kept: 1'b0, want: '0};
		return r;
	endfunction

	function automatic row_t mk_pair(input logic [UB-1:0] u1, input logic [UB-1:0] u2,
			input logic typed, input logic kept, input logic [31:0] v, input logic s);
		row_t r;
		r = '{kind: ROW_PAIR, loc: '0, scl: '0, u1: u1, u2: u2,
			typed: typed, kept: kept, want: '{variate: v, saturated: s}};
		return r;
	endfunction

	function automatic logic [UB-1:0] pick_edge();
		case ($urandom_range(6))
			0: return 24'h000000;
			1: return 24'h000001;
			2: return 24'h7FFFFF;
			3: return 24'h800000;
			4: return 24'h800001;
			5: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// offer one pair, with random gaps unless quiet; queue what it should yield
	task automatic send_pair(input logic [UB-1:0] u1, input logic [UB-1:0] u2,
			input logic typed, input logic kept, input draw_t want,
			output logic yields);
		draw_t d;
		while (!quiet && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {u2, u1};
		do @(posedge clk); while (!s_tready);
		yields = predict_draw(u1, u2, d);
		if (typed) begin
			yields = kept;
			d = want;
		end
		if (yields) begin
			pending_draws.push_back(d);
			n_kept++;
		end
		n_pairs++;
	endtask

	// stop offering and wait for the pipe to empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// two beats back to back on the register channel
	task automatic write_regs(input logic [31:0] loc, input logic [31:0] scl);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LOCATION;
		cfg_data  <= loc;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_SCALE;
		cfg_data  <= scl;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		loc_q   = loc;
		scale_q = scl[SCALE_W-1:0];
	endtask

	// result side: check each beat, then pick the next ready level
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_draws.size() == 0) begin
				report_mismatch("draw with nothing pending", '0, m_tdata);
			end else begin
				head_draw = pending_draws.pop_front();
				if (m_tdata !== head_draw.variate)
					report_mismatch("variate", head_draw.variate, m_tdata);
				if (m_tuser !== head_draw.saturated)
					report_mismatch("saturated", 32'(head_draw.saturated), 32'(m_tuser));
				n_draws++;
				if (m_tuser) n_sat++;
			end
		end
		if (stall_req && !stall_taken) begin
			hold_left = HOLD_CYCLES;
			stall_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 21);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d draws pending",
				IDLE_LIMIT, pending_draws.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [UB-1:0] u1, u2;
		logic [31:0] loc, scl;
		logic yields;
		logic paused;
		int sel, got;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_LOCATION;
		cfg_data    = '0;
		quiet       = 1'b0;
		stall_req   = 1'b0;
		stall_taken = 1'b0;
		hold_left   = 0;
		idle_cycles = 0;
		errors      = 0;
		n_pairs     = 0;
		n_kept      = 0;
		n_draws     = 0;
		n_sat       = 0;
		paused      = 1'b0;
		loc_q       = LOC_RESET;
		scale_q     = SCALE_RESET;

		// reset values: location 0, scale 1.0
		plan.push_back(mk_pair(24'h800000, 24'h000000, 1, 1, 32'h0000_0000, 0)); // on the circle
		plan.push_back(mk_pair(24'h000000, 24'h800000, 1, 0, '0, 0));            // zero divisor
		plan.push_back(mk_pair(24'h000000, 24'h000000, 1, 0, '0, 0));            // outside
		plan.push_back(mk_pair(24'hFFFFFF, 24'hFFFFFF, 1, 0, '0, 0));            // outside
		plan.push_back(mk_pair(24'h800001, 24'h800001, 1, 1, 32'h0001_0000, 0));
		plan.push_back(mk_pair(24'h7FFFFF, 24'h800001, 1, 1, 32'hFFFF_0000, 0));
		plan.push_back(mk_pair(24'hC00000, 24'h800001, 1, 1, 32'h7FFF_FFFF, 1));
		plan.push_back(mk_pair(24'h400000, 24'h800001, 1, 1, 32'h8000_0000, 1));
		plan.push_back(mk_pair(24'hFFFFFF, 24'h800001, 0, 0, '0, 0));
		plan.push_back(mk_pair(24'h800000, 24'hFFFFFF, 0, 0, '0, 0));
		plan.push_back(mk_pair(24'h123456, 24'hABCDEF, 0, 0, '0, 0));
		// both registers at their top
		plan.push_back(mk_setup(32'h7FFF_FFFF, 32'h7FFF_FFFF));
		plan.push_back(mk_pair(24'h800001, 24'h800001, 1, 1, 32'h7FFF_FFFF, 1));
		plan.push_back(mk_pair(24'h7FFFFF, 24'h800001, 1, 1, 32'h0000_0000, 0));
		plan.push_back(mk_pair(24'h800001, 24'h000000, 0, 0, '0, 0));
		// most negative location, smallest scale
		plan.push_back(mk_setup(32'h8000_0000, 32'h0000_0001));
		plan.push_back(mk_pair(24'h7FFFFF, 24'h800001, 1, 1, 32'h8000_0000, 1));
		plan.push_back(mk_pair(24'h800001, 24'h800001, 1, 1, 32'h8000_0001, 0));
		plan.push_back(mk_pair(24'hDA0000, 24'h700000, 0, 0, '0, 0));
		// scale of zero once the ignored top bit is dropped
		plan.push_back(mk_setup(32'h1234_5678, 32'h8000_0000));
		plan.push_back(mk_pair(24'hC00000, 24'h800001, 1, 1, 32'h1234_5678, 0));
		plan.push_back(mk_pair(24'h3FFFFF, 24'hC00000, 0, 0, '0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP) begin
				settle();
				write_regs(plan[i].loc, plan[i].scl);
			end else begin
				send_pair(plan[i].u1, plan[i].u2, plan[i].typed, plan[i].kept,
					plan[i].want, yields);
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: begin loc = 32'h0000_0000; scl = 32'h0001_0000; end
				1: begin loc = $urandom;      scl = $urandom;      end
				2: begin loc = 32'h7FFF_FFFF; scl = 32'h0000_0001; end
				3: begin loc = 32'h8000_0000; scl = 32'h7FFF_FFFF; end
				default: begin loc = $urandom; scl = $urandom_range(1, 1 << 20); end
			endcase
			quiet <= (ph == 1);
			write_regs(loc, scl);
			got = 0;
			while (got < PHASE_DRAWS) begin
				sel = $urandom_range(99);
				if (sel < 60) begin
					u1 = 24'($urandom);
					u2 = 24'($urandom);
				end else if (sel < 75) begin
					// divisor near zero: large ratios, saturation
					u1 = 24'($urandom);
					u2 = 24'h800000 + 24'($urandom_range(64)) - 24'd32;
				end else if (sel < 88) begin
					u1 = 24'h800000 + 24'($urandom_range(64)) - 24'd32;
					u2 = 24'($urandom);
				end else begin
					u1 = pick_edge();
					u2 = pick_edge();
				end
				send_pair(u1, u2, 1'b0, 1'b0, '0, yields);
				if (yields) got++;
				if (ph == 2 && got == 40) stall_req <= 1'b1;
				if (ph == 3 && got == 100 && !paused) begin
					paused = 1'b1;
					settle();
				end
			end
		end

		settle();
		$display("covered %0d pairs, %0d inside the circle, %0d draws checked",
			n_pairs, n_kept, n_draws);
		$display("%0d draws clamped, across the directed and five random register settings",
			n_sat);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
